[rtl/svpr_pkg.sv]
// Shared types and constants for the servo PWM ramp generator.
// Queue entry, divider request/response, back-end state and CSR codes.
// No dependencies.
package svpr_pkg;

   localparam int DUTY_W     = 16;
   localparam int PERIOD_W   = 16;
   localparam int RATE_W     = 8;
   localparam int DUR_W      = 10;
   localparam int CHAN_W     = 2;
   localparam int STEP_W     = 21;
   localparam int MAG_W      = 20;              // |goal - live| * 10
   localparam int DIVS_W     = DUR_W + RATE_W;  // duration * rate
   localparam int STEP_SCALE = 10;
   localparam int MAX_CHANNELS = 8;
   localparam int QUEUE_DEPTH  = 2;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd39430;
   localparam logic [RATE_W-1:0]   RATE_RESET   = 8'd45;

   // register index, taken from paddr[2]
   localparam logic CSR_FRAME_PERIOD = 1'b0;
   localparam logic CSR_RAMP_RATE    = 1'b1;

   typedef logic [DUTY_W-1:0] duty_type;

   localparam duty_type NEUTRAL_DUTY [MAX_CHANNELS] = '{
      16'd3000, 16'd2839, 16'd2874, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
   };

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_RAMP = 2'd1,
      OP_NOP  = 2'd2
   } op_type;

   typedef struct packed {
      op_type              op;
      logic                ch_ok;
      logic [CHAN_W-1:0]   channel;
      duty_type            target;
      logic [DUR_W-1:0]    duration;
   } entry_type;

   typedef struct packed {
      logic                start;
      logic [MAG_W-1:0]    dividend;
      logic [DIVS_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [MAG_W-1:0]    quotient;
   } div_rsp_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_PREP = 2'd1,
      BK_DIV  = 2'd2,
      BK_DONE = 2'd3
   } back_state_type;

endpackage

[rtl/svpr_front.sv]
// Request front end: classifies each request and pushes it into the queue.
// Depends on svpr_pkg.
module svpr_front import svpr_pkg::*; #(
   parameter int CHANNELS = 3
) (
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_command,
   input  logic [CHAN_W-1:0]   req_channel,
   input  duty_type            req_target_duty,
   input  logic [DUR_W-1:0]    req_ramp_duration,
   input  logic                q_full,
   output logic                q_push,
   output entry_type           q_entry
);

   logic ch_ok;

   assign ch_ok     = 4'(req_channel) < 4'(CHANNELS);
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_entry.ch_ok   = ch_ok;
      q_entry.channel = req_channel;
      q_entry.target  = req_target_duty;
      // zero duration counts as one unit
      q_entry.duration = (req_ramp_duration == '0) ? DUR_W'(1) : req_ramp_duration;
      if (!req_command) begin
         q_entry.op = OP_TICK;
      end else if (ch_ok) begin
         q_entry.op = OP_RAMP;
      end else begin
         q_entry.op = OP_NOP;
      end
   end

endmodule

[rtl/svpr_queue.sv]
// Short FIFO between front end and back end.
// Depends on svpr_pkg.
module svpr_queue import svpr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      full,
   output logic      empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full  = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue pop while empty");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
         (pop && !push) |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("queue count out of step with pops");
`endif

endmodule

[rtl/svpr_div.sv]
// Restoring divider, one quotient bit per cycle, for the ramp step.
// Depends on svpr_pkg.
module svpr_div import svpr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int REM_W  = DIVS_W + 1;
   localparam int ITER_W = $clog2(MAG_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [MAG_W-1:0]  quo_ff, quo_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DIVS_W-1:0] dsr_ff, dsr_in;
   logic [REM_W-1:0]  shifted;
   logic [REM_W-1:0]  trial;
   logic              ge;

   assign shifted = {rem_ff[REM_W-2:0], quo_ff[MAG_W-1]};
   assign ge      = shifted >= {1'b0, dsr_ff};
   assign trial   = shifted - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         iter_in = ITER_W'(MAG_W);
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[MAG_W-2:0], ge};
         rem_in  = ge ? trial : shifted;
         iter_in = iter_ff - ITER_W'(1);
         if (iter_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

[rtl/svpr_back.sv]
// Back end: executes ticks and ramp commands on the channel state and
// holds the response register. Depends on svpr_pkg; drives svpr_div.
module svpr_back import svpr_pkg::*; #(
   parameter int CHANNELS   = 3,
   parameter int COUNT_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  entry_type           q_head,
   input  logic                q_empty,
   output logic                q_pop,
   input  logic [PERIOD_W-1:0] frame_period,
   input  logic [RATE_W-1:0]   ramp_rate,
   output div_req_type         div_req,
   input  div_rsp_type         div_rsp,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_level_pan,
   output logic                rsp_level_steer,
   output logic                rsp_level_motor,
   output duty_type            rsp_current_duty
);

   localparam int PIN_N = (CHANNELS > 3) ? CHANNELS : 3;
   localparam int CMP_W = ((COUNT_BITS > PERIOD_W) ? COUNT_BITS : PERIOD_W) + 1;

   back_state_type state_ff, state_in;

   logic [COUNT_BITS-1:0]   count_ff [CHANNELS];
   logic [COUNT_BITS-1:0]   count_in [CHANNELS];
   duty_type                live_ff  [CHANNELS];
   duty_type                live_in  [CHANNELS];
   duty_type                frame_ff [CHANNELS];
   duty_type                frame_in [CHANNELS];
   duty_type                goal_ff  [CHANNELS];
   duty_type                goal_in  [CHANNELS];
   logic signed [STEP_W-1:0] step_ff [CHANNELS];
   logic signed [STEP_W-1:0] step_in [CHANNELS];
   logic [PIN_N-1:0]        pin_ff, pin_in;

   logic [CHAN_W-1:0] ramp_ch_ff, ramp_ch_in;
   duty_type          ramp_tgt_ff, ramp_tgt_in;
   logic [DUR_W-1:0]  ramp_dur_ff, ramp_dur_in;
   logic              neg_ff, neg_in;

   logic     rsp_valid_ff, rsp_valid_in;
   logic     rsp_pan_ff, rsp_pan_in;
   logic     rsp_steer_ff, rsp_steer_in;
   logic     rsp_motor_ff, rsp_motor_in;
   duty_type rsp_duty_ff, rsp_duty_in;

   logic out_free;
   logic tick_go, nop_go, ramp_go, div_go, commit;

   duty_type            ramp_live;
   logic [DUTY_W:0]     diff;
   logic [DUTY_W:0]     diff_abs;
   logic [RATE_W-1:0]   rate_eff;
   logic [STEP_W-1:0]   q_ext;
   logic signed [STEP_W-1:0] step_new;
   logic [CHAN_W-1:0]   sel_ch;
   logic                sel_ok;
   duty_type            sel_duty;

   function automatic duty_type slew(input duty_type cur, input duty_type goal,
                                     input logic signed [STEP_W-1:0] st);
      logic signed [STEP_W+1:0] nv;
      logic signed [STEP_W+1:0] gw;
      logic                     up;
      logic                     down;
      nv   = $signed({{(STEP_W+2-DUTY_W){1'b0}}, cur}) + $signed({{2{st[STEP_W-1]}}, st});
      gw   = $signed({{(STEP_W+2-DUTY_W){1'b0}}, goal});
      up   = !st[STEP_W-1] && (st != '0);
      down = st[STEP_W-1];
      if ((up && nv >= gw) || (down && nv <= gw)) begin
         nv = gw;
      end
      return nv[DUTY_W-1:0];
   endfunction

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty && out_free && q_head.op == OP_RAMP) begin
               state_in = BK_PREP;
            end
         end
         BK_PREP: state_in = BK_DIV;
         BK_DIV: begin
            if (div_rsp.done) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
      endcase
   end

   // state outputs
   always_comb begin
      q_pop   = 1'b0;
      tick_go = 1'b0;
      nop_go  = 1'b0;
      ramp_go = 1'b0;
      div_go  = 1'b0;
      commit  = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            q_pop = !q_empty && out_free;
            unique case (q_head.op)
               OP_TICK: tick_go = q_pop;
               OP_RAMP: ramp_go = q_pop;
               default: nop_go  = q_pop;
            endcase
         end
         BK_PREP: div_go = 1'b1;
         BK_DIV:  ;
         BK_DONE: commit = out_free;
      endcase
   end

   // ramp setup: difference magnitude scaled by ten, sign kept apart; divisor duration * rate
   always_comb begin
      ramp_live = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (4'(ramp_ch_ff) == 4'(c)) begin
            ramp_live = live_ff[c];
         end
      end
   end

   assign diff     = {1'b0, ramp_tgt_ff} - {1'b0, ramp_live};
   assign diff_abs = diff[DUTY_W] ? (~diff + (DUTY_W+1)'(1)) : diff;
   assign rate_eff = (ramp_rate == '0) ? RATE_W'(1) : ramp_rate;

   always_comb begin
      div_req.start    = div_go;
      div_req.dividend = MAG_W'(diff_abs[DUTY_W-1:0]) * MAG_W'(STEP_SCALE);
      div_req.divisor  = DIVS_W'(ramp_dur_ff) * DIVS_W'(rate_eff);
   end

   assign q_ext    = {1'b0, div_rsp.quotient};
   assign step_new = neg_ff ? (~q_ext + STEP_W'(1)) : q_ext;

   always_comb begin
      ramp_ch_in  = ramp_go ? q_head.channel  : ramp_ch_ff;
      ramp_tgt_in = ramp_go ? q_head.target   : ramp_tgt_ff;
      ramp_dur_in = ramp_go ? q_head.duration : ramp_dur_ff;
      neg_in      = div_go ? diff[DUTY_W] : neg_ff;
   end

   // channel state update: frame advance on a tick, goal and step on commit
   always_comb begin
      logic [CMP_W-1:0] cnt_wide;
      cnt_wide = '0;
      pin_in   = pin_ff;
      for (int c = 0; c < CHANNELS; c++) begin
         count_in[c] = count_ff[c];
         live_in[c]  = live_ff[c];
         frame_in[c] = frame_ff[c];
         goal_in[c]  = goal_ff[c];
         step_in[c]  = step_ff[c];
         if (tick_go) begin
            cnt_wide = CMP_W'(count_ff[c]);
            if (count_ff[c] == '0) begin
               frame_in[c] = live_ff[c];
               live_in[c]  = slew(live_ff[c], goal_ff[c], step_ff[c]);
            end
            pin_in[c] = cnt_wide < CMP_W'(frame_in[c]);
            if (cnt_wide + CMP_W'(1) >= CMP_W'(frame_period)) begin
               count_in[c] = '0;
            end else begin
               count_in[c] = count_ff[c] + COUNT_BITS'(1);
            end
         end
         if (commit && 4'(ramp_ch_ff) == 4'(c)) begin
            goal_in[c] = ramp_tgt_ff;
            step_in[c] = step_new;
         end
      end
   end

   // response register
   assign sel_ch = (state_ff == BK_DONE) ? ramp_ch_ff : q_head.channel;
   assign sel_ok = (state_ff == BK_DONE) ? 1'b1 : q_head.ch_ok;

   always_comb begin
      sel_duty = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (4'(sel_ch) == 4'(c)) begin
            sel_duty = live_in[c];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pan_in   = rsp_pan_ff;
      rsp_steer_in = rsp_steer_ff;
      rsp_motor_in = rsp_motor_ff;
      rsp_duty_in  = rsp_duty_ff;
      if (tick_go || nop_go || commit) begin
         rsp_valid_in = 1'b1;
         rsp_pan_in   = pin_in[0];
         rsp_steer_in = pin_in[1];
         rsp_motor_in = pin_in[2];
         rsp_duty_in  = sel_ok ? sel_duty : '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         pin_ff       <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            count_ff[c] <= '0;
            live_ff[c]  <= NEUTRAL_DUTY[c];
            frame_ff[c] <= NEUTRAL_DUTY[c];
            goal_ff[c]  <= '0;
            step_ff[c]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pin_ff       <= pin_in;
         for (int c = 0; c < CHANNELS; c++) begin
            count_ff[c] <= count_in[c];
            live_ff[c]  <= live_in[c];
            frame_ff[c] <= frame_in[c];
            goal_ff[c]  <= goal_in[c];
            step_ff[c]  <= step_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      ramp_ch_ff   <= ramp_ch_in;
      ramp_tgt_ff  <= ramp_tgt_in;
      ramp_dur_ff  <= ramp_dur_in;
      neg_ff       <= neg_in;
      rsp_pan_ff   <= rsp_pan_in;
      rsp_steer_ff <= rsp_steer_in;
      rsp_motor_ff <= rsp_motor_in;
      rsp_duty_ff  <= rsp_duty_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_level_pan    = rsp_pan_ff;
   assign rsp_level_steer  = rsp_steer_ff;
   assign rsp_level_motor  = rsp_motor_ff;
   assign rsp_current_duty = rsp_duty_ff;

`ifndef SYNTHESIS
   a_busy_no_pop: assert property (@(posedge clock) disable iff (reset)
         (state_ff != BK_IDLE) |-> !q_pop)
      else $error("queue popped while a ramp is in progress");
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
         div_rsp.done |-> state_ff == BK_DIV)
      else $error("divider finished outside the divide state");
   a_commit_resp: assert property (@(posedge clock) disable iff (reset)
         commit |=> rsp_valid && rsp_current_duty == $past(live_ff[0]) ||
                    rsp_valid && $past(ramp_ch_ff) != '0)
      else $error("ramp commit did not load the response register");
`endif

endmodule

[rtl/servo_pwm_ramp_generator.sv]
// Servo PWM ramp generator, top level: CSR block, front end, queue,
// back end and divider. Depends on svpr_pkg and all svpr_* modules.
//
// Usage: each request on the req_ channel is either a timer tick
// (req_command 0) or a ramp command (req_command 1) for req_channel.
// Every request yields exactly one response on the rsp_ channel with the
// three pin levels after the request and the live duty of the addressed
// channel (0 for a channel that does not exist).
// Flow: a tick or an ignored ramp passes through the queue and the response
// register; ticks sustain one per cycle while rsp_ready stays high. A ramp
// command steps through the back end: a setup state, the bit-serial step
// divider (20 quotient bits, then its done flag) and a commit state; requests
// behind it wait in the two-entry queue.
// Stall: when rsp_ready is low the response register holds; the queue
// keeps accepting until it is full, then req_ready drops.
// Reset: synchronous; duties return to their neutral values, counters,
// goals and steps to zero, frame_period to 39430 and ramp_rate to 45.
// CSRs (APB, pready always high): 0x0 frame_period, 0x4 ramp_rate; write
// only while the block is idle.
module servo_pwm_ramp_generator import svpr_pkg::*; #(
   parameter int CHANNELS   = 3,
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_command,
   input  logic [CHAN_W-1:0]     req_channel,
   input  logic [DUTY_W-1:0]     req_target_duty,
   input  logic [DUR_W-1:0]      req_ramp_duration,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_level_pan,
   output logic                  rsp_level_steer,
   output logic                  rsp_level_motor,
   output logic [DUTY_W-1:0]     rsp_current_duty,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic                csr_wr;

   entry_type   push_entry;
   entry_type   head;
   logic        q_push, q_pop, q_full, q_empty;
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      period_in = period_ff;
      rate_in   = rate_ff;
      if (csr_wr) begin
         unique case (paddr[2])
            CSR_FRAME_PERIOD: period_in = pwdata[PERIOD_W-1:0];
            CSR_RAMP_RATE:    rate_in   = pwdata[RATE_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         CSR_FRAME_PERIOD: prdata = CSR_DATA_W'(period_ff);
         CSR_RAMP_RATE:    prdata = CSR_DATA_W'(rate_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         rate_ff   <= RATE_RESET;
      end else begin
         period_ff <= period_in;
         rate_ff   <= rate_in;
      end
   end

   svpr_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_channel       (req_channel),
      .req_target_duty   (req_target_duty),
      .req_ramp_duration (req_ramp_duration),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_entry           (push_entry)
   );

   svpr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (head),
      .full       (q_full),
      .empty      (q_empty)
   );

   svpr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   svpr_back #(
      .CHANNELS   (CHANNELS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_head           (head),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .frame_period     (period_ff),
      .ramp_rate        (rate_ff),
      .div_req          (div_req),
      .div_rsp          (div_rsp),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_level_pan    (rsp_level_pan),
      .rsp_level_steer  (rsp_level_steer),
      .rsp_level_motor  (rsp_level_motor),
      .rsp_current_duty (rsp_current_duty)
   );

endmodule

[verif/tb_servo_pwm_ramp_generator.sv]
// Self-checking testbench for servo_pwm_ramp_generator: tick and ramp requests,
// response checking against an in-bench duty/slew predictor, APB register setup.
// Depends on svpr_pkg and the servo_pwm_ramp_generator RTL.
module tb_servo_pwm_ramp_generator;
   import svpr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int  NUM_CH      = 3;
   localparam int  CYCLE_LIMIT = 400000;
   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_RAMP   = 1'b1;

   typedef struct {
      logic     level_pan;
      logic     level_steer;
      logic     level_motor;
      duty_type current_duty;
   } pwm_response_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_command;
   logic [CHAN_W-1:0]     req_channel;
   logic [DUTY_W-1:0]     req_target_duty;
   logic [DUR_W-1:0]      req_ramp_duration;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_level_pan;
   logic                  rsp_level_steer;
   logic                  rsp_level_motor;
   logic [DUTY_W-1:0]     rsp_current_duty;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   servo_pwm_ramp_generator DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_channel       (req_channel),
      .req_target_duty   (req_target_duty),
      .req_ramp_duration (req_ramp_duration),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_level_pan     (rsp_level_pan),
      .rsp_level_steer   (rsp_level_steer),
      .rsp_level_motor   (rsp_level_motor),
      .rsp_current_duty  (rsp_current_duty),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // predictor state
   logic [PERIOD_W-1:0] period_setting;
   logic [RATE_W-1:0]   rate_setting;
   logic [15:0]         tick_count   [NUM_CH];
   duty_type            duty_now     [NUM_CH];
   duty_type            duty_latched [NUM_CH];
   duty_type            duty_goal    [NUM_CH];
   int                  slew_step    [NUM_CH];
   logic                pin_now      [NUM_CH];

   pwm_response_type expected_responses[$];

   int  error_count     = 0;
   int  request_count   = 0;
   int  ramp_count      = 0;
   int  ignored_count   = 0;
   int  setting_count   = 0;
   int  response_count  = 0;
   int  long_hold_len   = 0;
   int  cycle_count     = 0;
   bit  idle_enable     = 1'b1;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d responses outstanding",
               cycle_count, expected_responses.size());
      $display("FAILED: results differ");
      $finish;
   end

   function automatic void reset_predictor();
      period_setting = PERIOD_RESET;
      rate_setting   = RATE_RESET;
      for (int c = 0; c < NUM_CH; c++) begin
         tick_count[c]   = '0;
         duty_now[c]     = NEUTRAL_DUTY[c];
         duty_latched[c] = NEUTRAL_DUTY[c];
         duty_goal[c]    = '0;
         slew_step[c]    = 0;
         pin_now[c]      = 1'b0;
      end
   endfunction

   function automatic pwm_response_type predict_pwm_response(
      input logic cmd, input logic [CHAN_W-1:0] ch,
      input duty_type tgt, input logic [DUR_W-1:0] dur);
      pwm_response_type rsp;
      int               nv;
      int               rate;
      int               units;
      int               diff;
      if (cmd == CMD_TICK) begin
         for (int c = 0; c < NUM_CH; c++) begin
            if (tick_count[c] == 0) begin
               // frame start: latch, then slew one step, clamped at the goal
               duty_latched[c] = duty_now[c];
               nv = int'(duty_now[c]) + slew_step[c];
               if ((slew_step[c] > 0 && nv >= int'(duty_goal[c])) ||
                   (slew_step[c] < 0 && nv <= int'(duty_goal[c])))
                  nv = int'(duty_goal[c]);
               duty_now[c] = nv[15:0];
            end
            pin_now[c] = (tick_count[c] < duty_latched[c]);
            if (int'(tick_count[c]) + 1 >= int'(period_setting))
               tick_count[c] = '0;
            else
               tick_count[c] = tick_count[c] + 16'd1;
         end
      end else if (ch < NUM_CH) begin
         rate  = (rate_setting == 0) ? 1 : int'(rate_setting);
         units = (dur == 0) ? 1 : int'(dur);
         duty_goal[ch] = tgt;
         diff = (int'(tgt) - int'(duty_now[ch])) * STEP_SCALE;
         slew_step[ch] = diff / (units * rate);
      end
      rsp.level_pan    = pin_now[0];
      rsp.level_steer  = pin_now[1];
      rsp.level_motor  = pin_now[2];
      rsp.current_duty = (ch < NUM_CH) ? duty_now[ch] : '0;
      return rsp;
   endfunction

   function automatic void compare_field(input string name, input logic [15:0] exp,
                                         input logic [15:0] act);
      if (act !== exp) begin
         error_count++;
         if (error_count <= 20)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
      end
   endfunction

   // responses are sampled mid-cycle; valid && ready there means taken at next edge
   initial begin
      pwm_response_type exp;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            response_count++;
            if (expected_responses.size() == 0) begin
               error_count++;
               if (error_count <= 20)
                  $display("%0t: unexpected response, expected none, actual duty %0d",
                           $time, rsp_current_duty);
            end else begin
               exp = expected_responses.pop_front();
               compare_field("level_pan", 16'(exp.level_pan), 16'(rsp_level_pan));
               compare_field("level_steer", 16'(exp.level_steer), 16'(rsp_level_steer));
               compare_field("level_motor", 16'(exp.level_motor), 16'(rsp_level_motor));
               compare_field("current_duty", exp.current_duty, rsp_current_duty);
            end
         end
      end
   end

   // response-side ready: random stalls, long hold-off on request
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (long_hold_len) @(posedge clock);
            long_hold_len = 0;
         end else if (idle_enable && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // Leaves valid high on return; the next call may still drop it for a random idle gap.
   task automatic send_request(input logic cmd, input logic [CHAN_W-1:0] ch,
                               input duty_type tgt, input logic [DUR_W-1:0] dur);
      logic accepted;
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_channel       <= ch;
      req_target_duty   <= tgt;
      req_ramp_duration <= dur;
      do begin
         @(negedge clock);
         accepted = req_ready;
         @(posedge clock);
      end while (accepted !== 1'b1);
      expected_responses.push_back(predict_pwm_response(cmd, ch, tgt, dur));
      request_count++;
      if (cmd == CMD_RAMP) ramp_count++;
      if (ch >= NUM_CH) ignored_count++;
   endtask

   task automatic stop_requests();
      req_valid <= 1'b0;
   endtask

   task automatic wait_for_responses();
      while (expected_responses.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_request();
      logic              cmd;
      logic [CHAN_W-1:0] ch;
      duty_type          tgt;
      logic [DUR_W-1:0]  dur;
      int                pick;
      cmd  = ($urandom_range(0, 3) == 0) ? CMD_RAMP : CMD_TICK;
      ch   = ($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, NUM_CH - 1));
      pick = $urandom_range(0, 7);
      if (pick == 0)
         tgt = '0;
      else if (pick == 1)
         tgt = '1;
      else if (pick == 2 && ch < NUM_CH)
         tgt = duty_now[ch] + 16'($urandom_range(0, 40)) - 16'd20;
      else
         tgt = 16'($urandom);
      pick = $urandom_range(0, 3);
      if (pick < 2)
         dur = 10'($urandom_range(0, 4));
      else if (pick == 2)
         dur = 10'($urandom_range(0, 40));
      else
         dur = 10'($urandom_range(0, 1023));
      send_request(cmd, ch, tgt, dur);
   endtask

   task automatic write_register(input logic idx, input logic [CSR_DATA_W-1:0] value);
      logic                  rdy;
      logic [CSR_DATA_W-1:0] mask;
      logic [CSR_DATA_W-1:0] readback;
      mask = (idx == CSR_FRAME_PERIOD) ? 32'h0000_FFFF : 32'h0000_00FF;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(negedge clock);
         rdy = pready;
         @(posedge clock);
      end while (rdy !== 1'b1);
      if (idx == CSR_FRAME_PERIOD)
         period_setting = value[PERIOD_W-1:0];
      else
         rate_setting = value[RATE_W-1:0];
      // back-to-back read of the same register
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(negedge clock);
         rdy      = pready;
         readback = prdata;
         @(posedge clock);
      end while (rdy !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      compare_field("register readback", 16'(value & mask), 16'(readback & mask));
   endtask

   task automatic apply_settings(input int period, input int rate);
      stop_requests();
      wait_for_responses();
      write_register(CSR_FRAME_PERIOD, 32'(period));
      write_register(CSR_RAMP_RATE, 32'(rate));
      setting_count++;
   endtask

   task automatic test_reset_defaults();
      send_request(CMD_TICK, 2'd0, 16'd0, 10'd0);
      send_request(CMD_RAMP, 2'd0, 16'd0, 10'd0);
      send_request(CMD_RAMP, 2'd1, 16'hFFFF, 10'd1023);
      send_request(CMD_RAMP, 2'd3, 16'h1234, 10'd7);        // no such channel
      send_request(CMD_TICK, 2'd3, 16'hFFFF, 10'h3FF);
      send_request(CMD_TICK, 2'd1, 16'd0, 10'd0);
      send_request(CMD_RAMP, 2'd2, 16'd2874, 10'd5);        // zero step
      stop_requests();
      wait_for_responses();
   endtask

   task automatic test_field_extremes();
      apply_settings(3, 255);
      send_request(CMD_RAMP, 2'd0, 16'hFFFF, 10'd1);
      send_request(CMD_RAMP, 2'd1, 16'd0, 10'd1023);
      send_request(CMD_RAMP, 2'd2, 16'd100, 10'd0);
      repeat (5) send_request(CMD_TICK, 2'd0, 16'd0, 10'd0);
      send_request(CMD_TICK, 2'd2, 16'hFFFF, 10'h3FF);
      stop_requests();
      wait_for_responses();
   endtask

   task automatic test_zero_settings();
      // both registers at zero behave as one
      apply_settings(0, 0);
      send_request(CMD_RAMP, 2'd2, 16'hFFFF, 10'd0);
      send_request(CMD_RAMP, 2'd0, 16'd5, 10'd2);
      repeat (3) send_request(CMD_TICK, 2'd0, 16'd0, 10'd0);
      send_request(CMD_TICK, 2'd2, 16'd0, 10'd0);
      stop_requests();
      wait_for_responses();
   endtask

   task automatic test_random_traffic(input int count, input int period, input int rate);
      apply_settings(period, rate);
      repeat (count) send_random_request();
      stop_requests();
      wait_for_responses();
   endtask

   task automatic test_queue_backpressure();
      apply_settings($urandom_range(2, 16), $urandom_range(1, 16));
      long_hold_len = 300;
      repeat (40) send_random_request();
      // sender waits for every response before resuming
      stop_requests();
      wait_for_responses();
      repeat (20) send_random_request();
      stop_requests();
      wait_for_responses();
   endtask

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_command       <= CMD_TICK;
      req_channel       <= '0;
      req_target_duty   <= '0;
      req_ramp_duration <= '0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      reset_predictor();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_field_extremes();
      test_zero_settings();
      test_random_traffic(350, $urandom_range(2, 12), $urandom_range(1, 8));
      test_random_traffic(200, 1, 255);
      test_random_traffic(150, 65535, 1);
      test_queue_backpressure();
      test_random_traffic(350, $urandom_range(1, 300), $urandom_range(1, 255));
      idle_enable = 1'b0;
      test_random_traffic(300, $urandom_range(2, 20), $urandom_range(1, 30));

      stop_requests();
      wait_for_responses();
      repeat (40) @(posedge clock);

      $display("Covered %0d requests (%0d ramps, %0d to a missing channel), %0d responses",
               request_count, ramp_count, ignored_count, response_count);
      $display("across %0d register settings, with stalls on both sides", setting_count);
      if (error_count == 0 && expected_responses.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/svpr_pkg.sv
rtl/svpr_front.sv
rtl/svpr_queue.sv
rtl/svpr_div.sv
rtl/svpr_back.sv
rtl/servo_pwm_ramp_generator.sv
verif/tb_servo_pwm_ramp_generator.sv
